// File: sv/cfcs_pkg.sv
// ----------------------------------------------------------------------------
// cfcs_pkg
// Shared types and constants of the circular floor/ceiling search block.
// ----------------------------------------------------------------------------
package cfcs_pkg;

  localparam int VALUE_W = 32;
  localparam int INDEX_W = 9;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_FLOOR  = 2'd2,
    MODE_CEIL   = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t                     mode;
    logic signed [VALUE_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic                      found;
    logic [INDEX_W-1:0]        target_index;
    logic signed [VALUE_W-1:0] target_value;
    logic                      wrapped;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic clear;     // empty the store
    logic append;    // write key at the end
    logic load;      // latch query key, rewind scan
    logic read;      // read entry at scan address
    logic addr_inc;  // advance scan address
    logic emit;      // register result and strobe it
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic last_addr;
  } dp_stat_t;

endpackage

// File: sv/cfcs_ram.sv
// ----------------------------------------------------------------------------
// cfcs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cfcs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: sv/cfcs_ctrl.sv
// ----------------------------------------------------------------------------
// cfcs_ctrl
// Sequencer: accepts commands, walks the scan and schedules the result.
// ----------------------------------------------------------------------------
module cfcs_ctrl
  import cfcs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  mode_t    mode,
  input  dp_stat_t stat,
  output logic     busy,
  output ctl_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (mode)
            MODE_CLEAR:  cmd.clear  = 1'b1;
            MODE_APPEND: cmd.append = 1'b1;
            MODE_FLOOR, MODE_CEIL: begin
              cmd.load  = 1'b1;
              state_nxt = stat.empty ? ST_EMIT : ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        cmd.read = 1'b1;
        if (stat.last_addr) begin
          state_nxt = ST_LAST;
        end else begin
          cmd.addr_inc = 1'b1;
        end
      end
      // last read data is compared in this cycle
      ST_LAST: state_nxt = ST_EMIT;
      ST_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != ST_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

// File: sv/cfcs_dp.sv
// ----------------------------------------------------------------------------
// cfcs_dp
// Datapath: entry store, fill count, scan address and one comparator pair
// that tracks the strict floor/ceiling candidate and the wrap extreme.
// ----------------------------------------------------------------------------
module cfcs_dp
  import cfcs_pkg::*;
#(
  parameter int STORE_DEPTH = 512
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_item,
  input  ctl_cmd_t  cmd,
  output dp_stat_t  stat,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int CW = $clog2(STORE_DEPTH + 1);

  logic [CW-1:0]             count_r;
  logic [AW-1:0]             addr_r;
  logic                      floor_r;
  logic signed [VALUE_W-1:0] key_r;
  logic                      rd_vld_r;
  logic [AW-1:0]             rd_idx_r;
  logic [VALUE_W-1:0]        rd_data;
  logic signed [VALUE_W-1:0] rd_val;
  logic                      have_r;
  logic signed [VALUE_W-1:0] cand_val_r, ext_val_r;
  logic [AW-1:0]             cand_idx_r, ext_idx_r;
  logic                      full;
  logic                      cand_hit, ext_hit;
  logic                      out_valid_r;
  out_item_t                 out_item_r;

  assign full = (count_r == CW'(STORE_DEPTH));

  cfcs_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (STORE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.append && !full),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (in_item.key),
    .rd_en   (cmd.read),
    .rd_addr (addr_r),
    .rd_data (rd_data)
  );

  assign rd_val = $signed(rd_data);

  assign stat.empty     = (count_r == '0);
  assign stat.last_addr = ((CW'(addr_r) + CW'(1)) == count_r);

  // strict candidate on the key side; extreme for the wrap fallback
  always_comb begin
    if (floor_r) begin
      cand_hit = (rd_val < key_r) && (!have_r || (rd_val > cand_val_r));
      ext_hit  = (rd_idx_r == '0) || (rd_val > ext_val_r);
    end else begin
      cand_hit = (rd_val > key_r) && (!have_r || (rd_val < cand_val_r));
      ext_hit  = (rd_idx_r == '0) || (rd_val < ext_val_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      addr_r      <= '0;
      rd_vld_r    <= 1'b0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r    <= cmd.read;
      out_valid_r <= cmd.emit;
      if (cmd.clear) begin
        count_r <= '0;
      end else if (cmd.append && !full) begin
        count_r <= count_r + CW'(1);
      end
      if (cmd.load) begin
        addr_r <= '0;
        have_r <= 1'b0;
      end else begin
        if (cmd.addr_inc) begin
          addr_r <= addr_r + AW'(1);
        end
        if (rd_vld_r && cand_hit) begin
          have_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r   <= in_item.key;
      floor_r <= (in_item.mode == MODE_FLOOR);
    end
    rd_idx_r <= addr_r;
    if (rd_vld_r && cand_hit) begin
      cand_val_r <= rd_val;
      cand_idx_r <= rd_idx_r;
    end
    if (rd_vld_r && ext_hit) begin
      ext_val_r <= rd_val;
      ext_idx_r <= rd_idx_r;
    end
    if (cmd.emit) begin
      if (count_r == '0) begin
        out_item_r <= '0;
      end else if (have_r) begin
        out_item_r.found        <= 1'b1;
        out_item_r.target_index <= INDEX_W'(cand_idx_r);
        out_item_r.target_value <= cand_val_r;
        out_item_r.wrapped      <= 1'b0;
      end else begin
        out_item_r.found        <= 1'b1;
        out_item_r.target_index <= INDEX_W'(ext_idx_r);
        out_item_r.target_value <= ext_val_r;
        out_item_r.wrapped      <= 1'b1;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// File: sv/circular_floor_ceiling_search_top.sv
// ----------------------------------------------------------------------------
// circular_floor_ceiling_search_top
// Ordered store of signed values with floor/ceiling queries that wrap.
// ----------------------------------------------------------------------------
// Clear and append leave busy low, so the next item can follow at once. A
// floor or ceiling query reads every stored entry once through the single
// read port of the entry RAM and one comparator pair: it holds busy until
// its result appears on out_item with out_valid high for exactly one cycle,
// in the cycle busy drops. out_valid is a strobe: capture the result in that
// cycle, since it is not held. Appends to a full store are dropped.
module circular_floor_ceiling_search_top
  import cfcs_pkg::*;
#(
  parameter int STORE_DEPTH = 512
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  cfcs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .mode  (in_item.mode),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  cfcs_dp #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// File: sv/cfcs_chk.sv
// ----------------------------------------------------------------------------
// cfcs_chk
// Port-level checks of the search block, bound to the top level.
// ----------------------------------------------------------------------------
module cfcs_chk
  import cfcs_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input in_item_t  in_item,
  input logic      out_valid,
  input out_item_t out_item
);

  logic acc;
  logic is_query;

  assign acc      = start && !busy;
  assign is_query = (in_item.mode == MODE_FLOOR) || (in_item.mode == MODE_CEIL);

  // a result only shows once the block has gone idle again
  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobed while busy");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && is_query) |=> busy)
    else $error("query accepted without going busy");

  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.found) |->
      (out_item.target_index == '0) && (out_item.target_value == '0) &&
      !out_item.wrapped)
    else $error("not-found result carries nonzero fields");

  // a query right after a clear sees an empty store
  a_clear_then_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (in_item.mode == MODE_CLEAR)) ##1 (acc && is_query) |->
      ##2 (out_valid && !out_item.found))
    else $error("query after clear did not report empty");

endmodule

bind circular_floor_ceiling_search_top cfcs_chk u_chk (.*);

// File: tb/sv/tb_circular_floor_ceiling_search_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_circular_floor_ceiling_search_top
// Self-checking bench for the circular floor/ceiling search block.
// ----------------------------------------------------------------------------
// A queue of items, built at time zero, feeds a clocked driver that inserts
// random gaps. Each accepted item updates a shadow copy of the entry store.
// Floor and ceiling queries push their predicted result. The monitor checks
// every strobed result against the oldest prediction, field by field. The
// stimulus covers the empty store, ties, wrap in both directions, full-range
// keys and one fill past the last entry, where the extra appends are dropped.
module tb_circular_floor_ceiling_search_top;
  import cfcs_pkg::*;

  localparam int STORE_DEPTH = 512;
  localparam int TAIL_CYCLES = STORE_DEPTH + 8;
  localparam int RANDOM_ITEMS = 950;

  typedef struct {
    in_item_t item;
    bit       settle_first;  // hold until every pending result is back
  } stim_item_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_valid;
  out_item_t out_item;

  // shadow of the block's store
  logic signed [VALUE_W-1:0] stored_vals [STORE_DEPTH];
  int                        stored_count = 0;

  stim_item_t pending_items[$];
  out_item_t  expected_results[$];

  // stimulus-side view of what is stored, used to pick keys near entries
  logic signed [VALUE_W-1:0] gen_vals[$];
  int                        n_queued = 0;

  int gap_left = 0;
  int quiet_left = 0;
  int error_count = 0;
  int items_sent = 0;
  int results_seen = 0;
  int wraps_seen = 0;
  int empty_queries = 0;
  int dropped_appends = 0;
  int peak_count = 0;

  circular_floor_ceiling_search_top #(
    .STORE_DEPTH(STORE_DEPTH)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Update the shadow store; return 1 with the expected result for a query.
  function automatic bit search_store(input in_item_t it, output out_item_t res);
    logic signed [VALUE_W-1:0] key_s;
    logic signed [VALUE_W-1:0] v;
    logic signed [VALUE_W-1:0] best_v;
    int                        best;
    bit                        have;
    bit                        is_floor;
    res = '0;
    key_s = it.key;
    best_v = '0;
    best = 0;
    have = 1'b0;
    is_floor = (it.mode == MODE_FLOOR);
    if (it.mode == MODE_CLEAR) begin
      stored_count = 0;
      return 1'b0;
    end
    if (it.mode == MODE_APPEND) begin
      if (stored_count < STORE_DEPTH) begin
        stored_vals[stored_count] = key_s;
        stored_count++;
        if (stored_count > peak_count) peak_count = stored_count;
      end else begin
        dropped_appends++;
      end
      return 1'b0;
    end
    if (stored_count == 0) begin
      empty_queries++;
      return 1'b1;
    end
    // strict compares keep the earliest position on ties
    for (int i = 0; i < stored_count; i++) begin
      v = stored_vals[i];
      if (is_floor ? (v < key_s && (!have || v > best_v))
                   : (v > key_s && (!have || v < best_v))) begin
        best = i;
        best_v = v;
        have = 1'b1;
      end
    end
    if (!have) begin
      // wrap: floor falls back to the maximum, ceiling to the minimum
      best = 0;
      best_v = stored_vals[0];
      for (int i = 1; i < stored_count; i++) begin
        v = stored_vals[i];
        if (is_floor ? (v > best_v) : (v < best_v)) begin
          best = i;
          best_v = v;
        end
      end
      res.wrapped = 1'b1;
    end
    res.found = 1'b1;
    res.target_index = INDEX_W'(best);
    res.target_value = best_v;
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    int r;
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      quiet_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  always @(posedge clk) begin : drive_items
    out_item_t res;
    logic      next_start;
    in_item_t  next_item;
    if (!rst_n) begin
      start <= 1'b0;
      in_item <= '0;
      gap_left = 0;
    end else begin
      next_start = start;
      next_item = in_item;
      if (start && !busy) begin
        if (search_store(in_item, res)) expected_results.push_back(res);
        items_sent++;
        next_start = 1'b0;
      end
      if (!next_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_items.size() > 0 &&
                     !(pending_items[0].settle_first &&
                       (expected_results.size() > 0 || busy))) begin
          next_item = pending_items[0].item;
          void'(pending_items.pop_front());
          next_start = 1'b1;
          gap_left = pick_gap();
        end
      end
      start <= next_start;
      in_item <= next_item;
    end
  end

  always @(posedge clk) begin : check_results
    out_item_t exp_r;
    if (rst_n && out_valid) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("result with no query pending: found=%0d index=%0d value=%0d wrapped=%0d",
               out_item.found, out_item.target_index, $signed(out_item.target_value),
               out_item.wrapped);
        error_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_item.wrapped === 1'b1) wraps_seen++;
        if (out_item.found !== exp_r.found) begin
          $error("found: expected %0d, got %0d", exp_r.found, out_item.found);
          error_count++;
        end
        if (out_item.target_index !== exp_r.target_index) begin
          $error("target_index: expected %0d, got %0d",
                 exp_r.target_index, out_item.target_index);
          error_count++;
        end
        if (out_item.target_value !== exp_r.target_value) begin
          $error("target_value: expected %0d, got %0d",
                 $signed(exp_r.target_value), $signed(out_item.target_value));
          error_count++;
        end
        if (out_item.wrapped !== exp_r.wrapped) begin
          $error("wrapped: expected %0d, got %0d", exp_r.wrapped, out_item.wrapped);
          error_count++;
        end
      end
    end
  end

  // Queue one item and keep the stimulus-side view of the store in step.
  function automatic void queue_item(input mode_t m, input logic [VALUE_W-1:0] k,
                                     input bit settle = 1'b0);
    stim_item_t s;
    s.item.mode = m;
    s.item.key = k;
    s.settle_first = settle;
    pending_items.push_back(s);
    case (m)
      MODE_CLEAR: begin
        gen_vals.delete();
        n_queued++;
      end
      MODE_APPEND: begin
        if (gen_vals.size() < STORE_DEPTH) begin
          gen_vals.push_back(k);
          n_queued++;
        end
      end
      default: n_queued++;
    endcase
  endfunction

  function automatic logic [VALUE_W-1:0] pick_key();
    int r;
    logic [VALUE_W-1:0] base;
    r = $urandom_range(0, 9);
    if (gen_vals.size() > 0 && r < 5) begin
      base = gen_vals[$urandom_range(0, gen_vals.size() - 1)];
      case ($urandom_range(0, 2))
        0: return base;
        1: return base + 1;
        default: return base - 1;
      endcase
    end
    if (r == 5) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return $urandom;
  endfunction

  function automatic mode_t pick_query();
    return $urandom_range(0, 1) ? MODE_FLOOR : MODE_CEIL;
  endfunction

  // Fill the store past its depth, query it, then empty it again.
  function automatic void queue_full_store();
    queue_item(MODE_CLEAR, $urandom, 1'b1);
    for (int i = 0; i < STORE_DEPTH - 1; i++) queue_item(MODE_APPEND, $urandom);
    queue_item(MODE_APPEND, 32'h7FFF_FFFF);
    // dropped: the store is full
    repeat (3) queue_item(MODE_APPEND, $urandom);
    queue_item(MODE_FLOOR, 32'h8000_0000);
    queue_item(MODE_CEIL, 32'h7FFF_FFFE);
    queue_item(MODE_CEIL, 32'h7FFF_FFFF);
    repeat (20) queue_item(pick_query(), pick_key());
    queue_item(MODE_CLEAR, $urandom);
  endfunction

  initial begin : build_stimulus
    int  n_app;
    int  n_qry;
    bit  narrow;
    bit  full_done;
    logic [VALUE_W-1:0] val;
    full_done = 1'b0;

    // directed: empty store, extremes, ties, wrap both ways
    queue_item(MODE_FLOOR, 32'h0000_0000);
    queue_item(MODE_CEIL, 32'hFFFF_FFFF);
    queue_item(MODE_APPEND, 32'h8000_0000);
    queue_item(MODE_APPEND, 32'h7FFF_FFFF);
    queue_item(MODE_APPEND, 32'h0000_0000);
    queue_item(MODE_APPEND, 32'h0000_0000);
    queue_item(MODE_APPEND, 32'hFFFF_FFFF);
    queue_item(MODE_FLOOR, 32'h0000_0000);
    queue_item(MODE_CEIL, 32'h0000_0000);
    queue_item(MODE_FLOOR, 32'h8000_0000);
    queue_item(MODE_CEIL, 32'h7FFF_FFFF);
    queue_item(MODE_FLOOR, 32'h0000_0001);
    queue_item(MODE_CEIL, 32'hFFFF_FFFF);
    queue_item(MODE_CLEAR, 32'hFFFF_FFFF);
    queue_item(MODE_FLOOR, 32'h5555_5555);
    queue_item(MODE_APPEND, 32'h0000_0005);
    queue_item(MODE_FLOOR, 32'h0000_0005);
    queue_item(MODE_CEIL, 32'h0000_0005);
    queue_item(MODE_CEIL, 32'h0000_0004);
    queue_item(MODE_CLEAR, 32'h0000_0000, 1'b1);

    while (n_queued < RANDOM_ITEMS + 20) begin
      if (!full_done && n_queued > 300) begin
        queue_full_store();
        full_done = 1'b1;
      end
      if ($urandom_range(0, 9) < 8)
        queue_item(MODE_CLEAR, $urandom, $urandom_range(0, 49) == 0);
      narrow = ($urandom_range(0, 2) == 0);
      case ($urandom_range(0, 9))
        0: n_app = 0;
        1: n_app = $urandom_range(20, 60);
        default: n_app = $urandom_range(1, 12);
      endcase
      for (int i = 0; i < n_app; i++) begin
        val = narrow ? VALUE_W'($signed($urandom_range(0, 15)) - 8) : $urandom;
        queue_item(MODE_APPEND, val);
        if ($urandom_range(0, 4) == 0) queue_item(pick_query(), pick_key());
      end
      n_qry = $urandom_range(1, 5);
      for (int i = 0; i < n_qry; i++) queue_item(pick_query(), pick_key());
      // noise: any mode with any key
      if ($urandom_range(0, 9) == 0) queue_item(mode_t'($urandom_range(0, 3)), $urandom);
    end
  end

  initial begin : finish_run
    wait (rst_n === 1'b1);
    @(negedge clk);
    while (pending_items.size() > 0 || start || expected_results.size() > 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("Ran %0d items; checked %0d query results, %0d of them wrapped, %0d on an empty store.",
             items_sent, results_seen, wraps_seen, empty_queries);
    $display("Store reached %0d entries; %0d appends to a full store were dropped.",
             peak_count, dropped_appends);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #40_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
